// ===== hw/rtl/oba_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oba_pkg
// Shared types, constants and helpers of the oriented box bound accumulator.
// ----------------------------------------------------------------------------
package oba_pkg;

  // Fixed-point constants: ln 2 in Q.30 and log2 e in Q.20.
  localparam logic [63:0] LN2_Q30   = 64'd744261118;
  localparam int          LOG2E_Q20 = 1512775;
  localparam int          CORNERS   = 8;
  localparam int          QBITS     = 31;  // quotient bits of one matrix entry

  typedef logic signed [31:0] pos_t;
  typedef logic signed [15:0] quat_t;
  typedef logic signed [15:0] lscale_t;
  typedef logic signed [31:0] prod_t;    // quaternion component products
  typedef logic        [32:0] n2_t;      // squared norm, up to 2^32
  typedef logic signed [34:0] num_t;     // matrix numerators
  typedef logic        [32:0] mag_t;
  typedef logic        [33:0] trial_t;
  typedef logic        [30:0] quo_t;
  typedef logic signed [31:0] rent_t;    // matrix entry, Q2.30
  typedef logic        [29:0] expv_t;    // half extent, Q14.16, never negative
  typedef logic signed [30:0] cval_t;    // signed corner offset
  typedef logic signed [37:0] tprod_t;   // log scale times log2 e
  typedef logic signed [5:0]  kexp_t;
  typedef logic        [4:0]  shamt_t;
  typedef logic signed [62:0] mprod_t;
  typedef logic signed [63:0] acc_t;
  typedef logic signed [33:0] vcoord_t;  // rotated corner plus centre

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PROD,
    ST_NUMER,
    ST_EXPSH,
    ST_DLOAD,
    ST_DITER,
    ST_DSTORE,
    ST_CMUL,
    ST_CSUM,
    ST_FOLD,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic       capture;
    logic       prod;
    logic       numer;
    logic       expsh;
    logic       div_load;
    logic       div_step;
    logic       div_store;
    logic       cmul;
    logic       csum;
    logic       fold;
    logic       clear;
    logic [1:0] div_row;
    logic [1:0] div_col;
    logic [1:0] row;
    logic [2:0] corner;
  } cmd_t;

  typedef struct packed {
    logic n2_zero;
    logic last;
  } status_t;

  // One exp table entry in Q1.30: the series of e^a up to its twelfth power.
  function automatic logic [31:0] exp_entry(input logic [63:0] a);
    logic [63:0] term;
    logic [63:0] sum;
    term = 64'd1 << 30;
    sum  = term;
    term = ((term * a) >> 30) / 64'd1;  sum = sum + term;
    term = ((term * a) >> 30) / 64'd2;  sum = sum + term;
    term = ((term * a) >> 30) / 64'd3;  sum = sum + term;
    term = ((term * a) >> 30) / 64'd4;  sum = sum + term;
    term = ((term * a) >> 30) / 64'd5;  sum = sum + term;
    term = ((term * a) >> 30) / 64'd6;  sum = sum + term;
    term = ((term * a) >> 30) / 64'd7;  sum = sum + term;
    term = ((term * a) >> 30) / 64'd8;  sum = sum + term;
    term = ((term * a) >> 30) / 64'd9;  sum = sum + term;
    term = ((term * a) >> 30) / 64'd10; sum = sum + term;
    term = ((term * a) >> 30) / 64'd11; sum = sum + term;
    term = ((term * a) >> 30) / 64'd12; sum = sum + term;
    return sum[31:0];
  endfunction

endpackage

// ===== hw/rtl/oriented_box_bound_accumulator_core.sv =====
`timescale 1ns / 1ps
// Products, squared norm and exp come first, then the nine matrix entries on the
// shared one-bit-per-cycle divider, then eight corners of three rows each on
// three multipliers; a zero quaternion skips the divider and the corners, and an
// item marked last passes the output state. One item is in work at a time.
// The bound of a last item moves to an output register and holds there until
// taken, while input goes on. Synchronous reset empties the bound and the output.
// ----------------------------------------------------------------------------
// oriented_box_bound_accumulator_core
// Folds the corners of oriented, exp-scaled boxes into a running bound.
// ----------------------------------------------------------------------------
module oriented_box_bound_accumulator_core #(
  parameter int COORD_WIDTH     = 32,
  parameter int EXP_TABLE_DEPTH = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic signed [15:0] quat_w,
  input  logic signed [15:0] quat_x,
  input  logic signed [15:0] quat_y,
  input  logic signed [15:0] quat_z,
  input  logic signed [15:0] log_scale_x,
  input  logic signed [15:0] log_scale_y,
  input  logic signed [15:0] log_scale_z,
  input  logic               last_item,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] bound_min_x,
  output logic signed [31:0] bound_min_y,
  output logic signed [31:0] bound_min_z,
  output logic signed [31:0] bound_max_x,
  output logic signed [31:0] bound_max_y,
  output logic signed [31:0] bound_max_z,
  output logic               bound_valid
);

  oba_pkg::cmd_t    cmd;
  oba_pkg::status_t status;

  oba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  oba_datapath #(
    .COORD_WIDTH     (COORD_WIDTH),
    .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .pos_z       (pos_z),
    .quat_w      (quat_w),
    .quat_x      (quat_x),
    .quat_y      (quat_y),
    .quat_z      (quat_z),
    .log_scale_x (log_scale_x),
    .log_scale_y (log_scale_y),
    .log_scale_z (log_scale_z),
    .last_item   (last_item),
    .bound_min_x (bound_min_x),
    .bound_min_y (bound_min_y),
    .bound_min_z (bound_min_z),
    .bound_max_x (bound_max_x),
    .bound_max_y (bound_max_y),
    .bound_max_z (bound_max_z),
    .bound_valid (bound_valid)
  );

  // A stalled result stays posted and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(bound_min_x)
      && $stable(bound_max_z) && $stable(bound_valid)))
    else $error("stalled result changed or dropped");

  // An accepted item always occupies the block: input stalls once the item is accepted.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("block not busy after accepting an item");

  // Once a result is posted the block is free for the next item.
  a_free_after_post: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !in_stall)
    else $error("input blocked after posting a result");

endmodule

// ===== hw/rtl/oba_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oba_ctrl
// Sequencer: steps the datapath through products, divisions and corners.
// ----------------------------------------------------------------------------
module oba_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  oba_pkg::status_t status,
  output oba_pkg::cmd_t    cmd
);

  oba_pkg::state_t state, state_next;
  logic [1:0] div_row, div_row_next;
  logic [1:0] div_col, div_col_next;
  logic [4:0] bit_cnt, bit_cnt_next;
  logic [1:0] row, row_next;
  logic [2:0] corner, corner_next;
  logic       out_full, out_full_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= oba_pkg::ST_IDLE;
      div_row  <= '0;
      div_col  <= '0;
      bit_cnt  <= '0;
      row      <= '0;
      corner   <= '0;
      out_full <= 1'b0;
    end else begin
      state    <= state_next;
      div_row  <= div_row_next;
      div_col  <= div_col_next;
      bit_cnt  <= bit_cnt_next;
      row      <= row_next;
      corner   <= corner_next;
      out_full <= out_full_next;
    end
  end

  always_comb begin
    state_next    = state;
    div_row_next  = div_row;
    div_col_next  = div_col;
    bit_cnt_next  = bit_cnt;
    row_next      = row;
    corner_next   = corner;
    out_full_next = out_full && out_stall;
    cmd           = '0;
    cmd.div_row   = div_row;
    cmd.div_col   = div_col;
    cmd.row       = row;
    cmd.corner    = corner;
    in_stall      = 1'b1;
    out_valid     = out_full;
    unique case (state)
      oba_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = oba_pkg::ST_PROD;
        end
      end
      oba_pkg::ST_PROD: begin
        cmd.prod   = 1'b1;
        state_next = oba_pkg::ST_NUMER;
      end
      oba_pkg::ST_NUMER: begin
        cmd.numer  = 1'b1;
        state_next = oba_pkg::ST_EXPSH;
      end
      oba_pkg::ST_EXPSH: begin
        cmd.expsh    = 1'b1;
        div_row_next = '0;
        div_col_next = '0;
        // A zero quaternion contributes no corners at all.
        if (status.n2_zero) begin
          state_next = status.last ? oba_pkg::ST_OUT : oba_pkg::ST_IDLE;
        end else begin
          state_next = oba_pkg::ST_DLOAD;
        end
      end
      oba_pkg::ST_DLOAD: begin
        cmd.div_load = 1'b1;
        bit_cnt_next = '0;
        state_next   = oba_pkg::ST_DITER;
      end
      oba_pkg::ST_DITER: begin
        cmd.div_step = 1'b1;
        bit_cnt_next = bit_cnt + 5'd1;
        if (bit_cnt == 5'(oba_pkg::QBITS - 1)) begin
          state_next = oba_pkg::ST_DSTORE;
        end
      end
      oba_pkg::ST_DSTORE: begin
        cmd.div_store = 1'b1;
        if (div_col == 2'd2) begin
          div_col_next = '0;
          if (div_row == 2'd2) begin
            row_next    = '0;
            corner_next = '0;
            state_next  = oba_pkg::ST_CMUL;
          end else begin
            div_row_next = div_row + 2'd1;
            state_next   = oba_pkg::ST_DLOAD;
          end
        end else begin
          div_col_next = div_col + 2'd1;
          state_next   = oba_pkg::ST_DLOAD;
        end
      end
      oba_pkg::ST_CMUL: begin
        cmd.cmul   = 1'b1;
        state_next = oba_pkg::ST_CSUM;
      end
      oba_pkg::ST_CSUM: begin
        cmd.csum = 1'b1;
        if (row == 2'd2) begin
          state_next = oba_pkg::ST_FOLD;
        end else begin
          row_next   = row + 2'd1;
          state_next = oba_pkg::ST_CMUL;
        end
      end
      oba_pkg::ST_FOLD: begin
        cmd.fold = 1'b1;
        row_next = '0;
        if (corner == 3'(oba_pkg::CORNERS - 1)) begin
          state_next = status.last ? oba_pkg::ST_OUT : oba_pkg::ST_IDLE;
        end else begin
          corner_next = corner + 3'd1;
          state_next  = oba_pkg::ST_CMUL;
        end
      end
      oba_pkg::ST_OUT: begin
        // The finished bound waits here until the output register is free.
        if (!out_full || !out_stall) begin
          cmd.clear     = 1'b1;
          out_full_next = 1'b1;
          state_next    = oba_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = oba_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/oba_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oba_datapath
// Products, exp lookup, serial divider, corner transform and running bound.
// ----------------------------------------------------------------------------
module oba_datapath #(
  parameter int COORD_WIDTH     = 32,
  parameter int EXP_TABLE_DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     rst,
  input  oba_pkg::cmd_t            cmd,
  output oba_pkg::status_t         status,
  input  logic signed [31:0]       pos_x,
  input  logic signed [31:0]       pos_y,
  input  logic signed [31:0]       pos_z,
  input  logic signed [15:0]       quat_w,
  input  logic signed [15:0]       quat_x,
  input  logic signed [15:0]       quat_y,
  input  logic signed [15:0]       quat_z,
  input  logic signed [15:0]       log_scale_x,
  input  logic signed [15:0]       log_scale_y,
  input  logic signed [15:0]       log_scale_z,
  input  logic                     last_item,
  output logic signed [31:0]       bound_min_x,
  output logic signed [31:0]       bound_min_y,
  output logic signed [31:0]       bound_min_z,
  output logic signed [31:0]       bound_max_x,
  output logic signed [31:0]       bound_max_y,
  output logic signed [31:0]       bound_max_z,
  output logic                     bound_valid
);

  localparam int IW  = (EXP_TABLE_DEPTH > 1) ? $clog2(EXP_TABLE_DEPTH) : 1;
  localparam int VW  = $bits(oba_pkg::vcoord_t);
  localparam int EXW = (COORD_WIDTH > VW) ? COORD_WIDTH + 1 : VW + 1;
  localparam int OW  = (COORD_WIDTH > 32) ? COORD_WIDTH : 32;
  localparam logic signed [EXW-1:0] CMAX_X = (EXW'(1) <<< (COORD_WIDTH - 1)) - EXW'(1);
  localparam logic signed [EXW-1:0] CMIN_X = -CMAX_X - EXW'(1);
  localparam logic signed [COORD_WIDTH-1:0] RUN_MAX_INIT = CMAX_X[COORD_WIDTH-1:0];
  localparam logic signed [COORD_WIDTH-1:0] RUN_MIN_INIT = CMIN_X[COORD_WIDTH-1:0];

  // Exp table, Q1.30, built at elaboration.
  logic [31:0] exp_rom [EXP_TABLE_DEPTH];
  for (genvar gi = 0; gi < EXP_TABLE_DEPTH; gi++) begin : g_rom
    localparam logic [63:0] TabArg = (64'(gi) * oba_pkg::LN2_Q30) / EXP_TABLE_DEPTH;
    assign exp_rom[gi] = oba_pkg::exp_entry(TabArg);
  end

  // Captured item.
  oba_pkg::pos_t    pos [3];
  oba_pkg::quat_t   qw, qx, qy, qz;
  oba_pkg::lscale_t lsc [3];
  logic             last;

  oba_pkg::prod_t   p_ww, p_xx, p_yy, p_zz, p_xy, p_wz, p_xz, p_wy, p_yz, p_wx;
  oba_pkg::tprod_t  tpr [3];
  oba_pkg::n2_t     n2;
  oba_pkg::num_t    num [3][3];
  logic [31:0]      exp_raw [3];
  oba_pkg::kexp_t   kexp [3];
  oba_pkg::expv_t   ev [3];

  oba_pkg::mag_t    rem;
  oba_pkg::quo_t    shin;
  oba_pkg::quo_t    quo;
  logic             neg;

  oba_pkg::rent_t   r_c0 [3];
  oba_pkg::rent_t   r_c1 [3];
  oba_pkg::rent_t   r_c2 [3];
  oba_pkg::mprod_t  mp [3];
  oba_pkg::vcoord_t vc [3];
  logic             ok;

  logic signed [COORD_WIDTH-1:0] run_min [3];
  logic signed [COORD_WIDTH-1:0] run_max [3];
  logic                          seen;

  // Combinational helpers.
  oba_pkg::n2_t     n2_c;
  logic [IW-1:0]    idx_c [3];
  logic [43:0]      iprod_c [3];
  oba_pkg::shamt_t  sa_c [3];
  oba_pkg::num_t    sel_c;
  oba_pkg::num_t    abs_c;
  oba_pkg::mag_t    mag_c;
  oba_pkg::trial_t  trial_c;
  logic             ge_c;
  oba_pkg::cval_t   cv_c [3];
  oba_pkg::acc_t    acc_c;
  oba_pkg::vcoord_t v_c;
  logic signed [EXW-1:0] vx_c;
  logic             inr_c;
  logic signed [COORD_WIDTH-1:0] vt_c [3];

  always_comb begin
    n2_c = oba_pkg::n2_t'(p_ww) + oba_pkg::n2_t'(p_xx)
         + oba_pkg::n2_t'(p_yy) + oba_pkg::n2_t'(p_zz);
    for (int a = 0; a < 3; a++) begin
      iprod_c[a] = {12'b0, tpr[a][31:0]} * 44'(EXP_TABLE_DEPTH);
      idx_c[a]   = iprod_c[a][32 +: IW];
      sa_c[a]    = oba_pkg::shamt_t'(oba_pkg::kexp_t'(14) - kexp[a]);
      cv_c[a]    = cmd.corner[a] ? oba_pkg::cval_t'({1'b0, ev[a]})
                                 : -oba_pkg::cval_t'({1'b0, ev[a]});
      vt_c[a]    = COORD_WIDTH'(vc[a]);
    end
    sel_c   = num[cmd.div_row][cmd.div_col];
    abs_c   = sel_c[34] ? -sel_c : sel_c;
    mag_c   = abs_c[32:0];
    trial_c = {rem, shin[30]};
    ge_c    = trial_c >= {1'b0, n2};
    acc_c   = oba_pkg::acc_t'(mp[0]) + oba_pkg::acc_t'(mp[1]) + oba_pkg::acc_t'(mp[2]);
    v_c     = oba_pkg::vcoord_t'(acc_c >>> 30) + oba_pkg::vcoord_t'(pos[cmd.row]);
    vx_c    = EXW'(v_c);
    inr_c   = (vx_c <= CMAX_X) && (vx_c >= CMIN_X);
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      pos[0] <= pos_x;
      pos[1] <= pos_y;
      pos[2] <= pos_z;
      qw     <= quat_w;
      qx     <= quat_x;
      qy     <= quat_y;
      qz     <= quat_z;
      lsc[0] <= log_scale_x;
      lsc[1] <= log_scale_y;
      lsc[2] <= log_scale_z;
      last   <= last_item;
    end
    if (cmd.prod) begin
      p_ww <= oba_pkg::prod_t'(qw) * oba_pkg::prod_t'(qw);
      p_xx <= oba_pkg::prod_t'(qx) * oba_pkg::prod_t'(qx);
      p_yy <= oba_pkg::prod_t'(qy) * oba_pkg::prod_t'(qy);
      p_zz <= oba_pkg::prod_t'(qz) * oba_pkg::prod_t'(qz);
      p_xy <= oba_pkg::prod_t'(qx) * oba_pkg::prod_t'(qy);
      p_wz <= oba_pkg::prod_t'(qw) * oba_pkg::prod_t'(qz);
      p_xz <= oba_pkg::prod_t'(qx) * oba_pkg::prod_t'(qz);
      p_wy <= oba_pkg::prod_t'(qw) * oba_pkg::prod_t'(qy);
      p_yz <= oba_pkg::prod_t'(qy) * oba_pkg::prod_t'(qz);
      p_wx <= oba_pkg::prod_t'(qw) * oba_pkg::prod_t'(qx);
      for (int a = 0; a < 3; a++) begin
        tpr[a] <= oba_pkg::tprod_t'(lsc[a]) * oba_pkg::tprod_t'(oba_pkg::LOG2E_Q20);
      end
    end
    if (cmd.numer) begin
      n2        <= n2_c;
      num[0][0] <= oba_pkg::num_t'(n2_c)
                 - ((oba_pkg::num_t'(p_yy) + oba_pkg::num_t'(p_zz)) <<< 1);
      num[0][1] <= (oba_pkg::num_t'(p_xy) - oba_pkg::num_t'(p_wz)) <<< 1;
      num[0][2] <= (oba_pkg::num_t'(p_xz) + oba_pkg::num_t'(p_wy)) <<< 1;
      num[1][0] <= (oba_pkg::num_t'(p_xy) + oba_pkg::num_t'(p_wz)) <<< 1;
      num[1][1] <= oba_pkg::num_t'(n2_c)
                 - ((oba_pkg::num_t'(p_xx) + oba_pkg::num_t'(p_zz)) <<< 1);
      num[1][2] <= (oba_pkg::num_t'(p_yz) - oba_pkg::num_t'(p_wx)) <<< 1;
      num[2][0] <= (oba_pkg::num_t'(p_xz) - oba_pkg::num_t'(p_wy)) <<< 1;
      num[2][1] <= (oba_pkg::num_t'(p_yz) + oba_pkg::num_t'(p_wx)) <<< 1;
      num[2][2] <= oba_pkg::num_t'(n2_c)
                 - ((oba_pkg::num_t'(p_xx) + oba_pkg::num_t'(p_yy)) <<< 1);
      for (int a = 0; a < 3; a++) begin
        exp_raw[a] <= exp_rom[idx_c[a]];
        kexp[a]    <= tpr[a][37:32];
      end
    end
    if (cmd.expsh) begin
      for (int a = 0; a < 3; a++) begin
        ev[a] <= oba_pkg::expv_t'(exp_raw[a] >> sa_c[a]);
      end
    end
    // Restoring division, one quotient bit a cycle. The dividend is the
    // magnitude times 2^30; its top part is already below n2.
    if (cmd.div_load) begin
      neg  <= sel_c[34];
      rem  <= mag_c >> 1;
      shin <= {mag_c[0], 30'b0};
      quo  <= '0;
    end
    if (cmd.div_step) begin
      rem  <= ge_c ? oba_pkg::mag_t'(trial_c - {1'b0, n2}) : trial_c[32:0];
      quo  <= {quo[29:0], ge_c};
      shin <= shin << 1;
    end
    if (cmd.div_store) begin
      case (cmd.div_col)
        2'd0:    r_c0[cmd.div_row] <= neg ? -oba_pkg::rent_t'(quo) : oba_pkg::rent_t'(quo);
        2'd1:    r_c1[cmd.div_row] <= neg ? -oba_pkg::rent_t'(quo) : oba_pkg::rent_t'(quo);
        default: r_c2[cmd.div_row] <= neg ? -oba_pkg::rent_t'(quo) : oba_pkg::rent_t'(quo);
      endcase
    end
    if (cmd.cmul) begin
      mp[0] <= oba_pkg::mprod_t'(r_c0[cmd.row]) * oba_pkg::mprod_t'(cv_c[0]);
      mp[1] <= oba_pkg::mprod_t'(r_c1[cmd.row]) * oba_pkg::mprod_t'(cv_c[1]);
      mp[2] <= oba_pkg::mprod_t'(r_c2[cmd.row]) * oba_pkg::mprod_t'(cv_c[2]);
    end
    if (cmd.csum) begin
      vc[cmd.row] <= v_c;
      ok          <= ((cmd.row == 2'd0) || ok) && inr_c;
    end
  end

  // Running bound.
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      for (int a = 0; a < 3; a++) begin
        run_min[a] <= RUN_MAX_INIT;
        run_max[a] <= RUN_MIN_INIT;
      end
      seen <= 1'b0;
    end else if (cmd.fold && ok) begin
      for (int a = 0; a < 3; a++) begin
        if (vt_c[a] < run_min[a]) begin
          run_min[a] <= vt_c[a];
        end
        if (vt_c[a] > run_max[a]) begin
          run_max[a] <= vt_c[a];
        end
      end
      seen <= 1'b1;
    end
  end

  logic signed [OW-1:0] omin [3];
  logic signed [OW-1:0] omax [3];
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      omin[a] = OW'(run_min[a]);
      omax[a] = OW'(run_max[a]);
    end
  end

  // Output register: the bound moves here in the same cycle the store clears.
  logic signed [31:0] res_min [3];
  logic signed [31:0] res_max [3];
  logic               res_seen;
  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      for (int a = 0; a < 3; a++) begin
        res_min[a] <= omin[a][31:0];
        res_max[a] <= omax[a][31:0];
      end
      res_seen <= seen;
    end
  end

  assign bound_min_x = res_min[0];
  assign bound_min_y = res_min[1];
  assign bound_min_z = res_min[2];
  assign bound_max_x = res_max[0];
  assign bound_max_y = res_max[1];
  assign bound_max_z = res_max[2];
  assign bound_valid = res_seen;

  assign status.n2_zero = (n2 == '0);
  assign status.last    = last;

endmodule

// ===== test/oriented_box_bound_accumulator_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oriented_box_bound_accumulator_checker
// Watches both channels of the box bound accumulator, predicts each bound
// from the accepted input items and compares the returned bounds in order.
// ----------------------------------------------------------------------------
module oriented_box_bound_accumulator_checker (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_stall,
  input  oba_pkg::pos_t    pos_x,
  input  oba_pkg::pos_t    pos_y,
  input  oba_pkg::pos_t    pos_z,
  input  oba_pkg::quat_t   quat_w,
  input  oba_pkg::quat_t   quat_x,
  input  oba_pkg::quat_t   quat_y,
  input  oba_pkg::quat_t   quat_z,
  input  oba_pkg::lscale_t log_scale_x,
  input  oba_pkg::lscale_t log_scale_y,
  input  oba_pkg::lscale_t log_scale_z,
  input  logic             last_item,
  input  logic             out_valid,
  input  logic             out_stall,
  input  oba_pkg::pos_t    bound_min_x,
  input  oba_pkg::pos_t    bound_min_y,
  input  oba_pkg::pos_t    bound_min_z,
  input  oba_pkg::pos_t    bound_max_x,
  input  oba_pkg::pos_t    bound_max_y,
  input  oba_pkg::pos_t    bound_max_z,
  input  logic             bound_valid,
  output int               errors,
  output int               pending
);

  localparam longint COORD_HI = 64'sd2147483647;
  localparam longint COORD_LO = -64'sd2147483648;

  typedef struct packed {
    oba_pkg::pos_t min_x, min_y, min_z, max_x, max_y, max_z;
    logic seen;
  } bound_t;

  logic [31:0] exp_tab [256];
  longint      lo_x, lo_y, lo_z, hi_x, hi_y, hi_z;
  logic        seen;
  bound_t      bound_q [$];

  initial begin
    for (int i = 0; i < 256; i++) begin
      logic [63:0] a, sum, term;
      a = (64'(i) * oba_pkg::LN2_Q30) / 64'd256;
      sum = 64'd1 << 30;
      term = sum;
      for (int n = 1; n <= 12; n++) begin
        term = ((term * a) >> 30) / 64'(n);
        sum = sum + term;
      end
      exp_tab[i] = sum[31:0];
    end
  end

  assign pending = bound_q.size();

  function automatic longint half_extent(oba_pkg::lscale_t s);
    longint      t;
    logic [63:0] u;
    int          k;
    t = longint'(s) * oba_pkg::LOG2E_Q20;
    u = t + (64'sd16 <<< 32);
    k = int'(u[63:32]) - 16;
    // With 256 entries the table index is the top byte of the fraction.
    return longint'(exp_tab[u[31:24]] >> (14 - k));
  endfunction

  function automatic longint ratio(longint num, longint n2);
    logic [63:0] mag;
    longint      q;
    mag = (num < 0) ? -num : num;
    q = longint'((mag << 30) / n2);
    return (num < 0) ? -q : q;
  endfunction

  task automatic clear_bound();
    lo_x = COORD_HI; lo_y = COORD_HI; lo_z = COORD_HI;
    hi_x = COORD_LO; hi_y = COORD_LO; hi_z = COORD_LO;
    seen = 1'b0;
  endtask

  task automatic fold_box();
    longint w, x, y, z, n2;
    longint ext [3];
    longint ctr [3];
    longint rm [3][3];
    longint c [3];
    longint v [3];
    longint acc;
    bit     ok;
    bound_t b;
    w = quat_w; x = quat_x; y = quat_y; z = quat_z;
    n2 = w * w + x * x + y * y + z * z;
    ext[0] = half_extent(log_scale_x);
    ext[1] = half_extent(log_scale_y);
    ext[2] = half_extent(log_scale_z);
    ctr[0] = pos_x; ctr[1] = pos_y; ctr[2] = pos_z;
    // A zero quaternion stands for a non-finite rotation: nothing is folded.
    if (n2 != 0) begin
      rm[0][0] = ratio(n2 - 2 * (y * y + z * z), n2);
      rm[0][1] = ratio(2 * (x * y - w * z), n2);
      rm[0][2] = ratio(2 * (x * z + w * y), n2);
      rm[1][0] = ratio(2 * (x * y + w * z), n2);
      rm[1][1] = ratio(n2 - 2 * (x * x + z * z), n2);
      rm[1][2] = ratio(2 * (y * z - w * x), n2);
      rm[2][0] = ratio(2 * (x * z - w * y), n2);
      rm[2][1] = ratio(2 * (y * z + w * x), n2);
      rm[2][2] = ratio(n2 - 2 * (x * x + y * y), n2);
      for (int i = 0; i < oba_pkg::CORNERS; i++) begin
        ok = 1'b1;
        for (int j = 0; j < 3; j++) c[j] = i[j] ? ext[j] : -ext[j];
        for (int r = 0; r < 3; r++) begin
          acc = 0;
          for (int j = 0; j < 3; j++) acc += rm[r][j] * c[j];
          v[r] = (acc >>> 30) + ctr[r];
          if (v[r] > COORD_HI || v[r] < COORD_LO) ok = 1'b0;
        end
        if (ok) begin
          if (v[0] < lo_x) lo_x = v[0];
          if (v[0] > hi_x) hi_x = v[0];
          if (v[1] < lo_y) lo_y = v[1];
          if (v[1] > hi_y) hi_y = v[1];
          if (v[2] < lo_z) lo_z = v[2];
          if (v[2] > hi_z) hi_z = v[2];
          seen = 1'b1;
        end
      end
    end
    if (last_item) begin
      b.min_x = lo_x[31:0]; b.min_y = lo_y[31:0]; b.min_z = lo_z[31:0];
      b.max_x = hi_x[31:0]; b.max_y = hi_y[31:0]; b.max_z = hi_z[31:0];
      b.seen = seen;
      bound_q.insert(bound_q.size(), b);
      clear_bound();
    end
  endtask

  task automatic cmp(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      errors++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    bound_t b;
    if (rst) begin
      clear_bound();
      bound_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (bound_q.size() == 0) begin
          errors++;
          $display("%0t: result item with no expected bound: expected none, actual %h",
                   $time, {bound_min_x, bound_min_y, bound_min_z, bound_max_x,
                           bound_max_y, bound_max_z, bound_valid});
        end else begin
          b = bound_q.pop_front();
          cmp("bound_min_x", b.min_x, bound_min_x);
          cmp("bound_min_y", b.min_y, bound_min_y);
          cmp("bound_min_z", b.min_z, bound_min_z);
          cmp("bound_max_x", b.max_x, bound_max_x);
          cmp("bound_max_y", b.max_y, bound_max_y);
          cmp("bound_max_z", b.max_z, bound_max_z);
          cmp("bound_valid", b.seen, bound_valid);
        end
      end
      if (in_valid && !in_stall) fold_box();
    end
  end

endmodule

// ===== test/oriented_box_bound_accumulator_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oriented_box_bound_accumulator_core_tb
// Drives directed and random boxes with random idling on both channels and
// a long output hold-off; the checker predicts and compares every bound.
// ----------------------------------------------------------------------------
module oriented_box_bound_accumulator_core_tb;

  localparam int RANDOM_ITEMS = 1200;
  localparam int HOLD_START   = 20000;
  localparam int HOLD_END     = 50000;
  localparam int CALM_START   = 60000;
  localparam int CALM_END     = 110000;

  logic             clk, rst;
  logic             in_valid, in_stall, out_valid, out_stall;
  oba_pkg::pos_t    pos_x, pos_y, pos_z;
  oba_pkg::quat_t   quat_w, quat_x, quat_y, quat_z;
  oba_pkg::lscale_t log_scale_x, log_scale_y, log_scale_z;
  logic             last_item;
  oba_pkg::pos_t    bound_min_x, bound_min_y, bound_min_z;
  oba_pkg::pos_t    bound_max_x, bound_max_y, bound_max_z;
  logic             bound_valid;
  int               errors, pending, cycle;

  oriented_box_bound_accumulator_core uut (.*);
  oriented_box_bound_accumulator_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("== FAIL ==");
    $finish;
  end

  always @(posedge clk) cycle <= cycle + 1;

  function automatic bit calm();
    return cycle >= CALM_START && cycle < CALM_END;
  endfunction

  // Receiver: random stalls, one long hold-off so the block backs up.
  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else if (cycle >= HOLD_START && cycle < HOLD_END) out_stall <= 1'b1;
    else out_stall <= !calm() && ($urandom_range(99) < 9);
  end

  task automatic send(oba_pkg::pos_t px, oba_pkg::pos_t py, oba_pkg::pos_t pz,
                      oba_pkg::quat_t qw, oba_pkg::quat_t qx, oba_pkg::quat_t qy,
                      oba_pkg::quat_t qz, oba_pkg::lscale_t sx, oba_pkg::lscale_t sy,
                      oba_pkg::lscale_t sz, logic lst);
    pos_x <= px; pos_y <= py; pos_z <= pz;
    quat_w <= qw; quat_x <= qx; quat_y <= qy; quat_z <= qz;
    log_scale_x <= sx; log_scale_y <= sy; log_scale_z <= sz;
    last_item <= lst;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    if (!calm() && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
  endtask

  function automatic oba_pkg::pos_t rand_pos();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $signed(32'($urandom_range(0, 1 << 26))) - (1 << 25);
      default: return $signed(32'($urandom_range(0, 1 << 22))) - (1 << 21);
    endcase
  endfunction

  function automatic oba_pkg::lscale_t rand_scale();
    if ($urandom_range(9) == 0) return oba_pkg::lscale_t'($urandom);
    return $signed(16'($urandom_range(0, 16384))) - 16'sd8192;
  endfunction

  function automatic oba_pkg::quat_t rand_quat();
    if ($urandom_range(19) == 0) return 16'sd0;
    return oba_pkg::quat_t'($urandom);
  endfunction

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    pos_x = 0; pos_y = 0; pos_z = 0;
    quat_w = 0; quat_x = 0; quat_y = 0; quat_z = 0;
    log_scale_x = 0; log_scale_y = 0; log_scale_z = 0;
    last_item = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty bound: a zero quaternion folds nothing.
    send(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1);
    // Identity rotation at the origin, unit extents, then a 90 degree turn.
    send(0, 0, 0, 16384, 0, 0, 0, 0, 0, 0, 1'b0);
    send(100 << 16, -5 << 16, 7 << 16, 11585, 0, 0, 11585, 4096, -4096, 0, 1'b1);
    // Field extremes, overflowing corners among them.
    send(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, -32768, -32768, -32768, -32768,
         32767, 32767, 32767, 1'b1);
    send(32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32767, 32767, 32767, 32767,
         -32768, -32768, -32768, 1'b1);
    send(0, 0, 0, -32768, 0, 0, 0, 32767, -32768, 0, 1'b0);
    send(32'sh7fff0000, 0, 0, 16384, 0, 0, 0, 8192, 8192, 8192, 1'b1);
    send(0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 1'b0);
    send(-1, -1, -1, 0, 1, 0, 0, -1, -1, -1, 1'b0);
    send(1, 1, 1, 0, 0, -1, 0, 1, 1, 1, 1'b0);
    send(0, 0, 0, 0, 0, 0, 32767, 12000, 0, -12000, 1'b1);
    send(5 << 16, 6 << 16, 7 << 16, 0, 0, 0, 0, 4096, 4096, 4096, 1'b0);
    send(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1);

    for (int i = 0; i < RANDOM_ITEMS; i++)
      send(rand_pos(), rand_pos(), rand_pos(), rand_quat(), rand_quat(), rand_quat(),
           rand_quat(), rand_scale(), rand_scale(), rand_scale(),
           (i == RANDOM_ITEMS - 1) || ($urandom_range(7) == 0));
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/oba_pkg.sv
hw/rtl/oba_ctrl.sv
hw/rtl/oba_datapath.sv
hw/rtl/oriented_box_bound_accumulator_core.sv
test/oriented_box_bound_accumulator_checker.sv
test/oriented_box_bound_accumulator_core_tb.sv
